// File: rtl/core/tcl_pkg.sv
// Shared types, constants and helper functions for the two-channel code lock.
// Used by every module under rtl/core; depends on nothing else.
package tcl_pkg;

	// Number of digits in a code; widths below follow from it.
	localparam int CODE_DIGITS = 4;
	localparam int CNT_W = $clog2(CODE_DIGITS + 1);
	localparam int IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

	// Keypad characters.
	localparam logic [7:0] KEY_ZERO = 8'h30;
	localparam logic [7:0] KEY_NINE = 8'h39;
	localparam logic [7:0] KEY_STAR = 8'h2A;
	localparam logic [7:0] KEY_HASH = 8'h23;

	// Remote command bytes for the digits 0 to 9.
	localparam logic [7:0] RC_CODE_0 = 8'h16;
	localparam logic [7:0] RC_CODE_1 = 8'h0C;
	localparam logic [7:0] RC_CODE_2 = 8'h18;
	localparam logic [7:0] RC_CODE_3 = 8'h5E;
	localparam logic [7:0] RC_CODE_4 = 8'h08;
	localparam logic [7:0] RC_CODE_5 = 8'h1C;
	localparam logic [7:0] RC_CODE_6 = 8'h5A;
	localparam logic [7:0] RC_CODE_7 = 8'h42;
	localparam logic [7:0] RC_CODE_8 = 8'h52;
	localparam logic [7:0] RC_CODE_9 = 8'h4A;

	typedef enum logic [1:0] {
		MODE_WAITING  = 2'd0,
		MODE_LOCKED   = 2'd1,
		MODE_UNLOCKED = 2'd2
	} mode_t;

	typedef enum logic [3:0] {
		EV_NONE        = 4'd0,
		EV_DIGIT       = 4'd1,
		EV_CLEARED     = 4'd2,
		EV_LOCKED      = 4'd3,
		EV_TOO_FEW     = 4'd4,
		EV_FULL        = 4'd5,
		EV_KEY_IGNORED = 4'd6,
		EV_UNKNOWN     = 4'd7,
		EV_CORRECT     = 4'd8,
		EV_WRONG       = 4'd9,
		EV_RC_IGNORED  = 4'd10
	} event_t;

	// Class of a request as decided by the front end.
	typedef enum logic [2:0] {
		CMD_KEY_DIGIT,
		CMD_KEY_CLEAR,
		CMD_KEY_LOCK,
		CMD_KEY_OTHER,
		CMD_RC_DIGIT,
		CMD_RC_UNKNOWN,
		CMD_RC_REPEAT
	} cmd_class_t;

	typedef struct packed {
		cmd_class_t  cls;
		logic [3:0]  digit;
	} cmd_t;

	typedef struct packed {
		mode_t       lock_mode;
		event_t      ev;
		logic [2:0]  count;
	} res_t;

	// Maps a remote byte to {hit, digit}; hit is low for an unknown byte.
	function automatic logic [4:0] remote_lookup(input logic [7:0] code);
		logic [4:0] r;
		case (code)
			RC_CODE_0: r = {1'b1, 4'd0};
			RC_CODE_1: r = {1'b1, 4'd1};
			RC_CODE_2: r = {1'b1, 4'd2};
			RC_CODE_3: r = {1'b1, 4'd3};
			RC_CODE_4: r = {1'b1, 4'd4};
			RC_CODE_5: r = {1'b1, 4'd5};
			RC_CODE_6: r = {1'b1, 4'd6};
			RC_CODE_7: r = {1'b1, 4'd7};
			RC_CODE_8: r = {1'b1, 4'd8};
			RC_CODE_9: r = {1'b1, 4'd9};
			default:   r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/core/tcl_classify.sv
// Front-end decoder: turns a raw keypad or remote request into a command class.
// Depends on tcl_pkg.
module tcl_classify
	import tcl_pkg::*;
(
	input  logic       kind,
	input  logic [7:0] key_code,
	input  logic       is_repeat,
	output cmd_t       cmd
);

	logic [4:0] rc_hit;

	assign rc_hit = remote_lookup(key_code);

	always_comb begin
		cmd.digit = 4'(key_code - KEY_ZERO);
		cmd.cls   = CMD_KEY_OTHER;
		if (kind) begin
			cmd.digit = rc_hit[3:0];
			if (is_repeat) begin
				cmd.cls = CMD_RC_REPEAT;
			end else if (rc_hit[4]) begin
				cmd.cls = CMD_RC_DIGIT;
			end else begin
				cmd.cls = CMD_RC_UNKNOWN;
			end
		end else if (key_code == KEY_STAR) begin
			cmd.cls = CMD_KEY_CLEAR;
		end else if (key_code == KEY_HASH) begin
			cmd.cls = CMD_KEY_LOCK;
		end else if (key_code inside {[KEY_ZERO:KEY_NINE]}) begin
			cmd.cls = CMD_KEY_DIGIT;
		end
	end

endmodule

// File: rtl/core/tcl_cmd_queue.sv
// Two-entry queue of decoded commands between the front end and the executor.
// Depends on tcl_pkg.
module tcl_cmd_queue
	import tcl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic valid,
	output cmd_t head
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push_ok;
	logic       pop_ok;

	assign full    = (cnt_q == 2'd2);
	assign valid   = (cnt_q != 2'd0);
	assign push_ok = push && !full;
	assign pop_ok  = pop && valid;
	assign head    = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_ok) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push_ok) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop_ok) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push_ok && !pop_ok) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop_ok && !push_ok) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("command queue count out of range");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push_ok && !pop_ok) |=> (cnt_q == $past(cnt_q) + 2'd1))
		else $error("command queue lost a request");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		((cnt_q == 2'd0) || (cnt_q == 2'd2)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("command queue pointers disagree with count");

endmodule

// File: rtl/core/tcl_exec.sv
// Back end: holds the lock state and code buffers, carries out one command per
// cycle while its two-entry output queue has room, and queues the results there. Depends on tcl_pkg.
module tcl_exec
	import tcl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] lock_mode,
	output logic [3:0] event_res,
	output logic [2:0] digit_count
);

	mode_t            mode_q, mode_d;
	logic [CNT_W-1:0] kc_q, kc_d;
	logic [CNT_W-1:0] rc_q, rc_d;
	logic [3:0]       saved_code_q    [CODE_DIGITS];
	logic [3:0]       keypad_digits_q [CODE_DIGITS];
	logic [3:0]       remote_digits_q [CODE_DIGITS];
	logic [3:0]       rc_next         [CODE_DIGITS];
	logic             kp_we, rc_we, save_code, code_match;
	event_t           ev;
	logic             locked;

	res_t             res_q [2];
	logic             res_wr_q, res_rd_q;
	logic [1:0]       res_cnt_q;
	logic             res_full, res_pop;
	res_t             res_new;

	assign locked   = (mode_q == MODE_LOCKED);
	assign res_full = (res_cnt_q == 2'd2);
	assign empty    = (res_cnt_q == 2'd0);
	assign res_pop  = pop && !empty;
	assign cmd_pop  = cmd_valid && !res_full;

	// Remote buffer with the incoming digit written in, for the final compare.
	always_comb begin
		code_match = 1'b1;
		for (int i = 0; i < CODE_DIGITS; i++) begin
			rc_next[i] = (rc_q[IDX_W-1:0] == IDX_W'(i)) ? cmd.digit : remote_digits_q[i];
			if (rc_next[i] != saved_code_q[i]) begin
				code_match = 1'b0;
			end
		end
	end

	always_comb begin
		mode_d    = mode_q;
		kc_d      = kc_q;
		rc_d      = rc_q;
		kp_we     = 1'b0;
		rc_we     = 1'b0;
		save_code = 1'b0;
		ev        = EV_NONE;
		if (cmd_pop) begin
			case (cmd.cls)
				CMD_KEY_DIGIT: begin
					if (locked) begin
						ev = EV_KEY_IGNORED;
					end else if (kc_q < CNT_W'(CODE_DIGITS)) begin
						kp_we = 1'b1;
						kc_d  = kc_q + 1'b1;
						ev    = EV_DIGIT;
					end else begin
						ev = EV_FULL;
					end
				end
				CMD_KEY_CLEAR: begin
					if (locked) begin
						ev = EV_KEY_IGNORED;
					end else begin
						kc_d = '0;
						ev   = EV_CLEARED;
					end
				end
				CMD_KEY_LOCK: begin
					if (locked) begin
						ev = EV_KEY_IGNORED;
					end else if (kc_q == CNT_W'(CODE_DIGITS)) begin
						save_code = 1'b1;
						mode_d    = MODE_LOCKED;
						kc_d      = '0;
						rc_d      = '0;
						ev        = EV_LOCKED;
					end else begin
						ev = EV_TOO_FEW;
					end
				end
				CMD_KEY_OTHER: begin
					ev = locked ? EV_KEY_IGNORED : EV_NONE;
				end
				CMD_RC_DIGIT: begin
					if (!locked) begin
						ev = EV_RC_IGNORED;
					end else begin
						rc_we = 1'b1;
						if (rc_q + 1'b1 == CNT_W'(CODE_DIGITS)) begin
							rc_d = '0;
							if (code_match) begin
								mode_d = MODE_UNLOCKED;
								kc_d   = '0;
								ev     = EV_CORRECT;
							end else begin
								ev = EV_WRONG;
							end
						end else begin
							rc_d = rc_q + 1'b1;
							ev   = EV_DIGIT;
						end
					end
				end
				CMD_RC_UNKNOWN: begin
					ev = locked ? EV_UNKNOWN : EV_RC_IGNORED;
				end
				CMD_RC_REPEAT: begin
					ev = EV_RC_IGNORED;
				end
				default: begin
					ev = EV_NONE;
				end
			endcase
		end
		res_new.lock_mode = mode_d;
		res_new.ev        = ev;
		res_new.count     = (mode_d == MODE_LOCKED) ? 3'(rc_d) : 3'(kc_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_WAITING;
			kc_q   <= '0;
			rc_q   <= '0;
		end else begin
			mode_q <= mode_d;
			kc_q   <= kc_d;
			rc_q   <= rc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (kp_we) begin
			keypad_digits_q[kc_q[IDX_W-1:0]] <= cmd.digit;
		end
		if (rc_we) begin
			remote_digits_q <= rc_next;
		end
		if (save_code) begin
			saved_code_q <= keypad_digits_q;
		end
		if (cmd_pop) begin
			res_q[res_wr_q] <= res_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_wr_q  <= 1'b0;
			res_rd_q  <= 1'b0;
			res_cnt_q <= 2'd0;
		end else begin
			if (cmd_pop) begin
				res_wr_q <= !res_wr_q;
			end
			if (res_pop) begin
				res_rd_q <= !res_rd_q;
			end
			if (cmd_pop && !res_pop) begin
				res_cnt_q <= res_cnt_q + 2'd1;
			end else if (res_pop && !cmd_pop) begin
				res_cnt_q <= res_cnt_q - 2'd1;
			end
		end
	end

	assign lock_mode   = res_q[res_rd_q].lock_mode;
	assign event_res   = res_q[res_rd_q].ev;
	assign digit_count = res_q[res_rd_q].count;

	a_mode_legal: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != 2'd3) else $error("lock mode took an unused value");

	a_rc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!locked |-> (rc_q == '0)) else $error("remote digits held while not locked");

	a_kc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		locked |-> (kc_q == '0)) else $error("keypad digits held while locked");

	a_rc_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rc_q < CNT_W'(CODE_DIGITS)) else $error("remote count reached a full code");

	a_res_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_cnt_q != 2'd3) else $error("result queue count out of range");

endmodule

// File: rtl/core/two_channel_code_lock_core.sv
// Top level of the two-channel code lock: decoder, command queue, executor.
// Depends on tcl_pkg, tcl_classify, tcl_cmd_queue and tcl_exec.
//
// The lock takes one request per clock cycle while full is low and gives
// exactly one result per request, in order. An accepted request is decoded
// into the command queue; the executor takes it from the head when the result
// queue has room and writes its result there, ready to be popped. The
// sustained rate is one request per cycle while results are popped, set by the
// executor, which retires one command each cycle against the lock state unless
// the result queue is full. Two-entry queues on both sides of the executor let
// the request side keep pushing while a result waits to be popped; full rises
// only once both queues have filled up.
module two_channel_code_lock_core
	import tcl_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic       kind,
	input  logic [7:0] key_code,
	input  logic       is_repeat,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] lock_mode,
	output logic [3:0] event_res,
	output logic [2:0] digit_count
);

	cmd_t dec_cmd;
	cmd_t head_cmd;
	logic head_valid;
	logic head_pop;

	tcl_classify u_classify (
		.kind      (kind),
		.key_code  (key_code),
		.is_repeat (is_repeat),
		.cmd       (dec_cmd)
	);

	tcl_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (dec_cmd),
		.full     (full),
		.pop      (head_pop),
		.valid    (head_valid),
		.head     (head_cmd)
	);

	tcl_exec u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (head_valid),
		.cmd         (head_cmd),
		.cmd_pop     (head_pop),
		.empty       (empty),
		.pop         (pop),
		.lock_mode   (lock_mode),
		.event_res   (event_res),
		.digit_count (digit_count)
	);

endmodule

// File: bench/tb_top.sv
// Self-checking bench for two_channel_code_lock_core: keypad and remote requests in,
// mode/event/count results out, checked against a lock model kept in this file.
// Depends on tcl_pkg and the RTL under rtl/core; reads and writes no files.
module tb_top
	import tcl_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic       kind = 1'b0;
	logic [7:0] key_code = 8'h00;
	logic       is_repeat = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [1:0] lock_mode;
	logic [3:0] event_res;
	logic [2:0] digit_count;

	// Remote bytes indexed by the digit they stand for.
	localparam logic [9:0][7:0] RC_BYTE = {RC_CODE_9, RC_CODE_8, RC_CODE_7, RC_CODE_6,
		RC_CODE_5, RC_CODE_4, RC_CODE_3, RC_CODE_2, RC_CODE_1, RC_CODE_0};

	// Lock state as the bench sees it.
	mode_t                          lk_mode = MODE_WAITING;
	logic [CODE_DIGITS-1:0][3:0]    lk_code = '0;
	logic [CODE_DIGITS-1:0][3:0]    lk_keys = '0;
	logic [CODE_DIGITS-1:0][3:0]    lk_remote = '0;
	int unsigned                    lk_key_cnt = 0;
	int unsigned                    lk_rc_cnt = 0;

	res_t lock_results_q[$];
	int   errors = 0;
	int   requests_sent = 0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_req = 0;
	int   hold_left = 0;

	two_channel_code_lock_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.kind(kind),
		.key_code(key_code),
		.is_repeat(is_repeat),
		.empty(empty),
		.pop(pop),
		.lock_mode(lock_mode),
		.event_res(event_res),
		.digit_count(digit_count)
	);

	always #1 clk = ~clk;

	// Advances the lock model by one request and returns the result it gives.
	function automatic res_t lock_predict(input logic k, input logic [7:0] c, input logic rep);
		res_t   r;
		event_t ev;
		int     d;
		d = -1;
		if (!k) begin
			if (lk_mode == MODE_LOCKED) begin
				ev = EV_KEY_IGNORED;
			end else if (c == KEY_STAR) begin
				lk_key_cnt = 0;
				ev = EV_CLEARED;
			end else if (c == KEY_HASH) begin
				if (lk_key_cnt == CODE_DIGITS) begin
					lk_code = lk_keys;
					lk_mode = MODE_LOCKED;
					lk_key_cnt = 0;
					lk_rc_cnt = 0;
					ev = EV_LOCKED;
				end else begin
					ev = EV_TOO_FEW;
				end
			end else if (c >= KEY_ZERO && c <= KEY_NINE) begin
				if (lk_key_cnt < CODE_DIGITS) begin
					lk_keys[lk_key_cnt] = 4'(c - KEY_ZERO);
					lk_key_cnt++;
					ev = EV_DIGIT;
				end else begin
					ev = EV_FULL;
				end
			end else begin
				ev = EV_NONE;
			end
		end else if (rep || lk_mode != MODE_LOCKED) begin
			ev = EV_RC_IGNORED;
		end else begin
			for (int i = 0; i < 10; i++)
				if (RC_BYTE[i] == c) d = i;
			if (d < 0) begin
				ev = EV_UNKNOWN;
			end else begin
				lk_remote[lk_rc_cnt] = 4'(d);
				lk_rc_cnt++;
				ev = EV_DIGIT;
				if (lk_rc_cnt == CODE_DIGITS) begin
					if (lk_remote == lk_code) begin
						lk_mode = MODE_UNLOCKED;
						lk_key_cnt = 0;
						ev = EV_CORRECT;
					end else begin
						ev = EV_WRONG;
					end
					lk_rc_cnt = 0;
				end
			end
		end
		r.lock_mode = lk_mode;
		r.ev = ev;
		r.count = (lk_mode == MODE_LOCKED) ? 3'(lk_rc_cnt) : 3'(lk_key_cnt);
		return r;
	endfunction

	// Offers one request after a random gap and waits until the lock takes it.
	task automatic send_request(input logic k, input logic [7:0] c, input logic rep);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		kind <= k;
		key_code <= c;
		is_repeat <= rep;
		do @(posedge clk); while (full);
		lock_results_q.push_back(lock_predict(k, c, rep));
		requests_sent++;
	endtask

	// Result side: checks each popped result and drives pop for the next edge.
	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (lock_results_q.size() == 0) begin
					$display("%0t: unexpected result mode %0d event %0d count %0d",
						$time, lock_mode, event_res, digit_count);
					errors++;
				end else begin
					want = lock_results_q.pop_front();
					if (lock_mode !== want.lock_mode) begin
						$display("%0t: lock_mode expected %0d got %0d",
							$time, want.lock_mode, lock_mode);
						errors++;
					end
					if (event_res !== want.ev) begin
						$display("%0t: event_res expected %0d got %0d",
							$time, want.ev, event_res);
						errors++;
					end
					if (digit_count !== want.count) begin
						$display("%0t: digit_count expected %0d got %0d",
							$time, want.count, digit_count);
						errors++;
					end
				end
			end
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// While not locked: enter a code and try to lock. While locked: try a code,
	// right about half the time, with the odd repeat frame in between.
	task automatic lock_attempt();
		int  n;
		bit  right;
		int  d;
		if (lk_mode != MODE_LOCKED) begin
			if ($urandom_range(3) == 0) send_request(1'b0, KEY_STAR, 1'($urandom_range(1)));
			n = ($urandom_range(4) == 0) ? $urandom_range(0, 6) : CODE_DIGITS - lk_key_cnt;
			for (int i = 0; i < n; i++)
				send_request(1'b0, 8'(KEY_ZERO + $urandom_range(9)), 1'($urandom_range(1)));
			send_request(1'b0, KEY_HASH, 1'($urandom_range(1)));
		end else begin
			right = 1'($urandom_range(1));
			for (int i = 0; i < CODE_DIGITS; i++) begin
				if ($urandom_range(7) == 0) send_request(1'b1, RC_BYTE[$urandom_range(9)], 1'b1);
				d = right ? int'(lk_code[i]) : $urandom_range(9);
				send_request(1'b1, RC_BYTE[d], 1'b0);
			end
		end
	endtask

	task automatic send_noise();
		case ($urandom_range(2))
			0: send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
				1'($urandom_range(1)));
			1: begin
				case ($urandom_range(2))
					0: send_request(1'b0, KEY_STAR, 1'($urandom_range(1)));
					1: send_request(1'b0, KEY_HASH, 1'($urandom_range(1)));
					default: send_request(1'b0, 8'(KEY_ZERO + $urandom_range(9)),
						1'($urandom_range(1)));
				endcase
			end
			default: send_request(1'b1, RC_BYTE[$urandom_range(9)],
				1'($urandom_range(3) == 0));
		endcase
	endtask

	task automatic test_directed();
		send_request(1'b0, KEY_STAR, 1'b0);
		send_request(1'b0, KEY_HASH, 1'b0);
		send_request(1'b0, 8'(KEY_ZERO + 5), 1'b0);
		send_request(1'b0, 8'h00, 1'b0);
		send_request(1'b0, 8'hFF, 1'b1);
		send_request(1'b1, 8'hFF, 1'b0);
		send_request(1'b1, RC_CODE_0, 1'b1);
		send_request(1'b0, KEY_ZERO, 1'b0);
		send_request(1'b0, KEY_NINE, 1'b0);
		send_request(1'b0, 8'(KEY_ZERO + 1), 1'b0);
		// Buffer is full now, so this digit is dropped.
		send_request(1'b0, 8'(KEY_ZERO + 7), 1'b0);
		send_request(1'b0, KEY_HASH, 1'b0);
		send_request(1'b0, 8'(KEY_ZERO + 3), 1'b0);
		send_request(1'b1, RC_CODE_5, 1'b1);
		send_request(1'b1, 8'h00, 1'b0);
		send_request(1'b1, RC_CODE_5, 1'b0);
		send_request(1'b1, RC_CODE_0, 1'b0);
		send_request(1'b1, RC_CODE_9, 1'b0);
		send_request(1'b1, RC_CODE_2, 1'b0);
		send_request(1'b1, RC_CODE_5, 1'b0);
		send_request(1'b1, RC_CODE_0, 1'b0);
		send_request(1'b1, RC_CODE_9, 1'b0);
		send_request(1'b1, RC_CODE_1, 1'b0);
		send_request(1'b1, RC_CODE_7, 1'b0);
		send_request(1'b0, KEY_STAR, 1'b0);
	endtask

	task automatic test_random_traffic(input int count);
		int stop_at;
		stop_at = requests_sent + count;
		while (requests_sent < stop_at) begin
			if ($urandom_range(99) < 60) lock_attempt();
			else send_noise();
		end
	endtask

	// The result side stops popping for a long stretch while requests keep
	// coming, so both internal queues fill and full has to stall the sender.
	task automatic test_full_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 60;
		repeat (4) lock_attempt();
	endtask

	initial begin
		send_idle_pct = 21;
		recv_idle_pct = 72;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic(180);
		send_idle_pct = 72;
		recv_idle_pct = 21;
		test_random_traffic(180);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(170);
		test_full_backpressure();
		push <= 1'b0;
		while (lock_results_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#400_000;
		$display("tb: failure");
		$finish;
	end

endmodule

// File: two_channel_code_lock_core.f
rtl/core/tcl_pkg.sv
rtl/core/tcl_classify.sv
rtl/core/tcl_cmd_queue.sv
rtl/core/tcl_exec.sv
rtl/core/two_channel_code_lock_core.sv
bench/tb_top.sv
